// ===== rtl/ascii_two_operand_calculator_top_assert.svh =====
// Assertion macros for the ASCII two-operand calculator.
`ifndef ASCII_TWO_OPERAND_CALCULATOR_TOP_ASSERT_SVH
`define ASCII_TWO_OPERAND_CALCULATOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ATOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("calculator assertion failed");
// next-cycle implication
`define ATOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("calculator assertion failed");
`else
`define ATOC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ATOC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== rtl/atoc_pkg.sv =====
// Shared types, constants and helpers for the ASCII two-operand calculator.
package atoc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_NEWLINE = 8'h0a;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2b;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_STAR    = 8'h2a;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_PERCENT = 8'h25;

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_REM  = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_OP   = 2'd2
  } status_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    op_t         op;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic op_t op_of(input logic [7:0] c);
    op_t o;
    case (c)
      CH_PLUS:    o = OP_ADD;
      CH_MINUS:   o = OP_SUB;
      CH_STAR:    o = OP_MUL;
      CH_SLASH:   o = OP_DIV;
      CH_PERCENT: o = OP_REM;
      default:    o = OP_NONE;
    endcase
    return o;
  endfunction

  // x*10 + digit, wrapping at 32 bits
  function automatic logic [31:0] acc10(input logic [31:0] x, input logic [7:0] c);
    logic [7:0] d;
    d = c - CH_ZERO;
    return (x << 3) + (x << 1) + {24'd0, d};
  endfunction

endpackage

// ===== rtl/atoc_if.sv =====
// Handshake interfaces for the character and result channels.
interface atoc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_line;

  modport source (output valid, output char_code, output end_of_line, input ready);
  modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

interface atoc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic        [1:0]  status;

  modport source (output valid, output result_value, output status, input ready);
  modport sink   (input valid, input result_value, input status, output ready);
endinterface

// ===== rtl/ascii_two_operand_calculator_top.sv =====
// Top level of the ASCII two-operand calculator.
// Channels: in_ch carries one character a beat (char_code, end_of_line); out_ch
// carries one result a beat (result_value, status) for every line.
// The parser takes one character per cycle while the job queue has room; in_ch.ready
// drops only when the queue is full.
// The beat with end_of_line set is parsed and its job is queued at the same edge.
// The job then goes from the queue through the unit to its result register and on to
// the output register that drives out_ch.valid; / and % also pass through the
// restoring divider, which resolves one quotient bit per cycle, and a sign-fix step.
// The arithmetic unit works on one line at a time and takes no new job until the last
// result is loaded into the output register; the slower of parser and unit sets the pace.
// Reset (synchronous, rst_n low) returns the parser to leading whitespace with
// cleared operands, empties the queue and drops out_ch.valid.
// When the receiver holds out_ch.ready low the result stays in the output
// register; the unit then stalls, the queue fills and in_ch.ready falls.
`include "ascii_two_operand_calculator_top_assert.svh"
module ascii_two_operand_calculator_top #(
  parameter int unsigned QueueDepth = atoc_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  atoc_in_if.sink     in_ch,
  atoc_out_if.source  out_ch
);

  atoc_pkg::job_t    push_job, head_job;
  atoc_pkg::q_stat_t q_stat;
  logic              job_push, job_pop;

  atoc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .job_push (job_push),
    .job      (push_job)
  );

  atoc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .pop      (job_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  atoc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job     (head_job),
    .q_stat  (q_stat),
    .job_pop (job_pop),
    .out_ch  (out_ch)
  );

  // every end-of-line beat lands in the queue
  `ATOC_ASSERT_IMP(a_eol_push, clk, rst_n, in_ch.valid && in_ch.ready && in_ch.end_of_line, job_push && !q_stat.full)
  `ATOC_ASSERT_IMP(a_pop_nonempty, clk, rst_n, job_pop, !q_stat.empty)
  `ATOC_ASSERT_NEXT(a_push_fills, clk, rst_n, job_push, !q_stat.empty)
  // error results carry zero
  `ATOC_ASSERT_IMP(a_err_zero, clk, rst_n, out_ch.valid && (out_ch.status != atoc_pkg::ST_OK), out_ch.result_value == 32'sd0)

endmodule

// ===== rtl/atoc_front.sv =====
// Front end: character parser that builds operands and the operator.
module atoc_front (
  input  logic              clk,
  input  logic              rst_n,
  atoc_in_if.sink           in_ch,
  input  atoc_pkg::q_stat_t q_stat,
  output logic              job_push,
  output atoc_pkg::job_t    job
);

  typedef enum logic [6:0] {
    PH_WS0  = 7'b0000001,
    PH_NUM1 = 7'b0000010,
    PH_WS1  = 7'b0000100,
    PH_OP   = 7'b0001000,
    PH_WS2  = 7'b0010000,
    PH_NUM2 = 7'b0100000,
    PH_STOP = 7'b1000000
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [31:0]     a_r, a_nxt;
  logic [31:0]     b_r, b_nxt;
  atoc_pkg::op_t   op_r, op_nxt;
  phase_t          ph;
  logic [31:0]     a_p, b_p;
  atoc_pkg::op_t   op_p, op_c;
  logic            sp, dg, done, accept;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;

  // A phase that cannot take the character hands it on to the next one.
  always_comb begin
    sp   = atoc_pkg::is_space(in_ch.char_code);
    dg   = atoc_pkg::is_digit(in_ch.char_code);
    op_c = atoc_pkg::op_of(in_ch.char_code);
    ph   = phase_r;
    a_p  = a_r;
    b_p  = b_r;
    op_p = op_r;
    done = 1'b0;
    if (ph == PH_WS0) begin
      if (sp) done = 1'b1;
      else ph = PH_NUM1;
    end
    if (!done && ph == PH_NUM1) begin
      if (dg) begin
        a_p  = atoc_pkg::acc10(a_r, in_ch.char_code);
        done = 1'b1;
      end else begin
        ph = PH_WS1;
      end
    end
    if (!done && ph == PH_WS1) begin
      if (sp) done = 1'b1;
      else ph = PH_OP;
    end
    if (!done && ph == PH_OP) begin
      ph = PH_WS2;
      if (op_c != atoc_pkg::OP_NONE) begin
        op_p = op_c;
        done = 1'b1;
      end
    end
    if (!done && ph == PH_WS2) begin
      if (sp) done = 1'b1;
      else ph = PH_NUM2;
    end
    if (!done && ph == PH_NUM2) begin
      if (dg) b_p = atoc_pkg::acc10(b_r, in_ch.char_code);
      else ph = PH_STOP;
      done = 1'b1;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    op_nxt    = op_r;
    if (accept) begin
      if (in_ch.end_of_line) begin
        phase_nxt = PH_WS0;
        a_nxt     = '0;
        b_nxt     = '0;
        op_nxt    = atoc_pkg::OP_NONE;
      end else begin
        phase_nxt = ph;
        a_nxt     = a_p;
        b_nxt     = b_p;
        op_nxt    = op_p;
      end
    end
  end

  assign job_push = accept && in_ch.end_of_line;
  assign job.a    = a_p;
  assign job.b    = b_p;
  assign job.op   = op_p;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WS0;
      a_r     <= '0;
      b_r     <= '0;
      op_r    <= atoc_pkg::OP_NONE;
    end else begin
      phase_r <= phase_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      op_r    <= op_nxt;
    end
  end

endmodule

// ===== rtl/atoc_queue.sv =====
// Small job queue between the parser and the arithmetic unit.
module atoc_queue #(
  parameter int unsigned Depth = atoc_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  atoc_pkg::job_t    push_job,
  input  logic              pop,
  output atoc_pkg::job_t    head_job,
  output atoc_pkg::q_stat_t stat
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  atoc_pkg::job_t  q_mem [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == CntW'(Depth));
  assign stat.empty = (cnt_r == '0);
  assign head_job   = q_mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop)      cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/atoc_back.sv =====
// Back end: arithmetic unit with a bit-serial divider and the result register.
module atoc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  atoc_pkg::job_t    job,
  input  atoc_pkg::q_stat_t q_stat,
  output logic              job_pop,
  atoc_out_if.source        out_ch
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_SIGN = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t              state_r, state_nxt;
  logic [31:0]         res_r, res_nxt;
  atoc_pkg::status_t   stat_r, stat_nxt;
  logic [31:0]         quo_r, quo_nxt;
  logic [31:0]         rem_r, rem_nxt;
  logic [31:0]         mb_r, mb_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                na_r, na_nxt;
  logic                nb_r, nb_nxt;
  logic                is_rem_r, is_rem_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [31:0]         out_val_r;
  atoc_pkg::status_t   out_stat_r;
  logic [32:0]         trial, diff;
  logic                ge, load;

  assign trial = {rem_r, quo_r[31]};
  assign diff  = trial - {1'b0, mb_r};
  assign ge    = !diff[32];
  assign load  = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign job_pop = (state_r == S_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt  = state_r;
    res_nxt    = res_r;
    stat_nxt   = stat_r;
    quo_nxt    = quo_r;
    rem_nxt    = rem_r;
    mb_nxt     = mb_r;
    cnt_nxt    = cnt_r;
    na_nxt     = na_r;
    nb_nxt     = nb_r;
    is_rem_nxt = is_rem_r;
    case (state_r)
      S_IDLE: begin
        if (job_pop) begin
          state_nxt = S_DONE;
          stat_nxt  = atoc_pkg::ST_OK;
          case (job.op)
            atoc_pkg::OP_ADD: res_nxt = job.a + job.b;
            atoc_pkg::OP_SUB: res_nxt = job.a - job.b;
            atoc_pkg::OP_MUL: res_nxt = 32'(job.a * job.b);
            atoc_pkg::OP_DIV, atoc_pkg::OP_REM: begin
              if (job.b == '0) begin
                res_nxt  = '0;
                stat_nxt = atoc_pkg::ST_DIV_ZERO;
              end else begin
                // divide magnitudes, fix signs afterwards
                na_nxt     = job.a[31];
                nb_nxt     = job.b[31];
                is_rem_nxt = (job.op == atoc_pkg::OP_REM);
                quo_nxt    = job.a[31] ? (32'd0 - job.a) : job.a;
                mb_nxt     = job.b[31] ? (32'd0 - job.b) : job.b;
                rem_nxt    = '0;
                cnt_nxt    = '0;
                state_nxt  = S_DIV;
              end
            end
            default: begin
              res_nxt  = '0;
              stat_nxt = atoc_pkg::ST_BAD_OP;
            end
          endcase
        end
      end
      S_DIV: begin
        rem_nxt = ge ? diff[31:0] : trial[31:0];
        quo_nxt = {quo_r[30:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd31) state_nxt = S_SIGN;
      end
      S_SIGN: begin
        if (is_rem_r) res_nxt = na_r ? (32'd0 - rem_r) : rem_r;
        else          res_nxt = (na_r != nb_r) ? (32'd0 - quo_r) : quo_r;
        stat_nxt  = atoc_pkg::ST_OK;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = load || (out_valid_r && !out_ch.ready);

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.status       = out_stat_r;

  always_ff @(posedge clk) begin
    res_r    <= res_nxt;
    stat_r   <= stat_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    mb_r     <= mb_nxt;
    cnt_r    <= cnt_nxt;
    na_r     <= na_nxt;
    nb_r     <= nb_nxt;
    is_rem_r <= is_rem_nxt;
    if (load) begin
      out_val_r  <= res_r;
      out_stat_r <= stat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
